/* src/lhm_pkg.sv */
// package of shared types, constants and helpers for the latency histogram monitor
`default_nettype none
package lhm_pkg;
    localparam int NUM_BOUNDS_DEF = 4;
    localparam int MAX_BOUNDS = 6;
    localparam int NUM_REGS = 6;
    localparam int REG_IDX_W = 3;
    localparam int QUEUE_DEPTH = 2;
    localparam logic [31:0] MICRO_PER_SEC = 32'd1000000;
    localparam logic [6:0] PERCENT_FULL = 7'd100;

    localparam logic [REG_IDX_W-1:0] REG_REAL_LIMIT = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_PROCESS_LIMIT = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_BOUND_0 = 3'd2;

    typedef enum logic [1:0] {
        REQ_EVENT = 2'd0,
        REQ_COLLECT = 2'd1,
        REQ_REPORT = 2'd2,
        REQ_NONE = 2'd3
    } req_type_t;

    typedef enum logic [1:0] {
        KIND_RATE = 2'd0,
        KIND_BIN = 2'd1,
        KIND_SUMMARY = 2'd2
    } out_kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVENT,
        ST_DIV,
        ST_RATE,
        ST_ROWS,
        ST_SUMMARY
    } back_state_t;

    // one classified request handed from front to back
    typedef struct packed {
        req_type_t  req;
        logic [2:0] real_bin;
        logic [2:0] process_bin;
        logic [2:0] wait_bin;
        logic       over_real;
        logic       over_process;
        logic [31:0] real_time;
        logic [31:0] process_time;
    } work_t;

    function automatic logic [31:0] bound_reset(input int i);
        case (i)
            0: bound_reset = 32'd10;
            1: bound_reset = 32'd100;
            2: bound_reset = 32'd1000;
            3: bound_reset = 32'd10000;
            4: bound_reset = 32'd100000;
            default: bound_reset = 32'd1000000;
        endcase
    endfunction
endpackage
`default_nettype wire

/* src/lhm_if.sv */
// valid/ready channel interfaces for requests, results and register writes
`default_nettype none
interface lhm_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [31:0] real_time;
    logic [31:0] process_time;
    modport source (output valid, req_type, real_time, process_time, input ready);
    modport sink (input valid, req_type, real_time, process_time, output ready);
endinterface

interface lhm_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  out_kind;
    logic [2:0]  bin_index;
    logic [31:0] value_a;
    logic [31:0] value_b;
    logic [31:0] value_c;
    logic [6:0]  real_percent;
    logic [6:0]  process_percent;
    logic [31:0] rate_min;
    logic [31:0] rate_max;
    logic        last;
    modport source (output valid, out_kind, bin_index, value_a, value_b, value_c,
        real_percent, process_percent, rate_min, rate_max, last, input ready);
    modport sink (input valid, out_kind, bin_index, value_a, value_b, value_c,
        real_percent, process_percent, rate_min, rate_max, last, output ready);
endinterface

interface lhm_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* src/lhm_front.sv */
// front end: register file, bin classification and limit compare
`default_nettype none
module lhm_front #(
    parameter int NUM_BOUNDS = lhm_pkg::NUM_BOUNDS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    lhm_cfg_if.sink          cfg,
    input  wire logic [1:0]  in_req_type,
    input  wire logic [31:0] in_real_time,
    input  wire logic [31:0] in_process_time,
    output lhm_pkg::work_t   work
);
    logic [31:0] real_limit_reg;
    logic [31:0] process_limit_reg;
    logic [31:0] bound_reg [NUM_BOUNDS];
    logic signed [33:0] wait_time;
    logic [2:0] real_bin;
    logic [2:0] process_bin;
    logic [2:0] wait_bin;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            real_limit_reg <= '0;
            process_limit_reg <= '0;
            for (int i = 0; i < NUM_BOUNDS; i++)
            begin
                bound_reg[i] <= lhm_pkg::bound_reset(i);
            end
        end
        else if (cfg.valid)
        begin
            if (cfg.index == lhm_pkg::REG_REAL_LIMIT)
            begin
                real_limit_reg <= cfg.data;
            end
            if (cfg.index == lhm_pkg::REG_PROCESS_LIMIT)
            begin
                process_limit_reg <= cfg.data;
            end
            for (int i = 0; i < NUM_BOUNDS; i++)
            begin
                if (i < lhm_pkg::NUM_REGS - 2 &&
                    {1'b0, cfg.index} == 4'(i) + {1'b0, lhm_pkg::REG_BOUND_0})
                begin
                    bound_reg[i] <= cfg.data;
                end
            end
        end
    end

    assign wait_time = $signed({2'b00, in_process_time}) - $signed({2'b00, in_real_time});

    always_comb
    begin
        real_bin = '0;
        process_bin = '0;
        wait_bin = '0;
        for (int i = 0; i < NUM_BOUNDS; i++)
        begin
            real_bin = real_bin + 3'(bound_reg[i] < in_real_time);
            process_bin = process_bin + 3'(bound_reg[i] < in_process_time);
            wait_bin = wait_bin + 3'($signed({2'b00, bound_reg[i]}) < wait_time);
        end
    end

    always_comb
    begin
        work.req = lhm_pkg::req_type_t'(in_req_type);
        work.real_bin = real_bin;
        work.process_bin = process_bin;
        work.wait_bin = wait_bin;
        work.over_real = in_real_time > real_limit_reg;
        work.over_process = in_process_time > process_limit_reg;
        work.real_time = in_real_time;
        work.process_time = in_process_time;
    end
endmodule
`default_nettype wire

/* src/lhm_queue.sv */
// two entry request queue between front and back
`default_nettype none
module lhm_queue (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    input  lhm_pkg::work_t push_data,
    output logic           full,
    output logic           not_empty,
    input  wire logic      pop,
    output lhm_pkg::work_t pop_data
);
    lhm_pkg::work_t entry_reg [lhm_pkg::QUEUE_DEPTH];
    logic wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;

    assign full = count_reg == 2'(lhm_pkg::QUEUE_DEPTH);
    assign not_empty = count_reg != 2'd0;
    assign pop_data = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) full |-> !push)
        else $error("queue overrun");
    assert property (@(posedge clk) disable iff (!rst_n) !not_empty |-> !pop)
        else $error("queue underrun");
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= 2'(lhm_pkg::QUEUE_DEPTH))
        else $error("queue count out of range");
endmodule
`default_nettype wire

/* src/lhm_div.sv */
// restoring divider, one quotient bit a cycle, 64 by 32 with saturation
`default_nettype none
module lhm_div (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [63:0] dividend,
    input  wire logic [31:0] divisor,
    output logic             busy,
    output logic [31:0]      quotient
);
    logic [63:0] quot_reg;
    logic [32:0] rem_reg;
    logic [31:0] div_reg;
    logic [6:0]  step_reg;
    logic [32:0] shifted;
    logic        fits;

    assign busy = step_reg != 7'd0;
    assign shifted = {rem_reg[31:0], quot_reg[63]};
    assign fits = shifted >= {1'b0, div_reg};
    assign quotient = (quot_reg[63:32] != '0) ? '1 : quot_reg[31:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
        end
        else if (start)
        begin
            step_reg <= 7'd64;
        end
        else if (busy)
        begin
            step_reg <= step_reg - 7'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quot_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (busy)
        begin
            rem_reg <= fits ? shifted - {1'b0, div_reg} : shifted;
            quot_reg <= {quot_reg[62:0], fits};
        end
    end
endmodule
`default_nettype wire

/* src/lhm_back.sv */
// back end: counters, histograms, rate division and result sequencing
`default_nettype none
module lhm_back #(
    parameter int NUM_BOUNDS = lhm_pkg::NUM_BOUNDS_DEF
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      work_valid,
    input  lhm_pkg::work_t work,
    output logic           work_pop,
    lhm_out_if.source      res
);
    localparam int NUM_BINS = NUM_BOUNDS + 1;

    lhm_pkg::back_state_t state_reg, state_next;
    lhm_pkg::work_t cur_reg;
    logic [31:0] period_count_reg, period_real_sum_reg, period_process_sum_reg;
    logic [31:0] finished_reg, over_real_reg, over_process_reg;
    logic [31:0] min_rate_reg, max_rate_reg;
    logic [31:0] real_hist_reg [NUM_BINS];
    logic [31:0] process_hist_reg [NUM_BINS];
    logic [31:0] wait_hist_reg [NUM_BINS];
    logic [31:0] real_rate_reg;
    logic        div_second_reg;
    logic [2:0]  row_reg;
    logic        out_valid_reg;
    logic [1:0]  out_kind_reg;
    logic [2:0]  bin_index_reg;
    logic [31:0] va_reg, vb_reg, vc_reg;
    logic [6:0]  rp_reg, pp_reg;
    logic        last_reg;

    logic        div_start, div_busy;
    logic [63:0] div_dividend;
    logic [31:0] div_divisor, div_q;
    logic [2:0]  row_sel;
    logic        out_free;
    logic        out_load;

    // percentage by compare and subtract: 100*over vs total, seven quotient bits
    function automatic logic [6:0] pct_of(input logic [31:0] over, input logic [31:0] total);
        logic [38:0] num;
        logic [39:0] rem;
        logic [6:0]  q;
        num = 39'(over) * 39'd100;
        rem = '0;
        q = '0;
        if (total == '0)
        begin
            pct_of = (over != '0) ? lhm_pkg::PERCENT_FULL : 7'd0;
        end
        else if (over >= total)
        begin
            pct_of = lhm_pkg::PERCENT_FULL;
        end
        else
        begin
            rem = {1'b0, num};
            for (int i = 6; i >= 0; i--)
            begin
                if (rem >= (40'(total) << i))
                begin
                    rem = rem - (40'(total) << i);
                    q[i] = 1'b1;
                end
            end
            pct_of = q;
        end
    endfunction

    lhm_div u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_dividend),
        .divisor(div_divisor), .busy(div_busy), .quotient(div_q)
    );

    assign out_free = !out_valid_reg || res.ready;
    assign out_load = out_free && (state_reg inside
        {lhm_pkg::ST_RATE, lhm_pkg::ST_ROWS, lhm_pkg::ST_SUMMARY});
    assign div_dividend = 64'(period_count_reg) * 64'(lhm_pkg::MICRO_PER_SEC);
    // real sum on the first start, process sum on the second
    assign div_divisor = (state_reg == lhm_pkg::ST_DIV) ? period_process_sum_reg
                                                         : period_real_sum_reg;
    assign row_sel = row_reg;

    always_comb
    begin
        state_next = state_reg;
        work_pop = 1'b0;
        div_start = 1'b0;
        case (state_reg)
            lhm_pkg::ST_IDLE:
            begin
                if (work_valid)
                begin
                    work_pop = 1'b1;
                    case (work.req)
                        lhm_pkg::REQ_EVENT: state_next = lhm_pkg::ST_EVENT;
                        lhm_pkg::REQ_COLLECT:
                        begin
                            state_next = lhm_pkg::ST_DIV;
                            div_start = 1'b1;
                        end
                        lhm_pkg::REQ_REPORT: state_next = lhm_pkg::ST_ROWS;
                        default: state_next = lhm_pkg::ST_IDLE;
                    endcase
                end
            end
            lhm_pkg::ST_EVENT: state_next = lhm_pkg::ST_IDLE;
            lhm_pkg::ST_DIV:
            begin
                if (!div_busy)
                begin
                    if (!div_second_reg)
                    begin
                        div_start = 1'b1;
                    end
                    else
                    begin
                        state_next = lhm_pkg::ST_RATE;
                    end
                end
            end
            lhm_pkg::ST_RATE:
            begin
                if (out_free)
                begin
                    state_next = lhm_pkg::ST_IDLE;
                end
            end
            lhm_pkg::ST_ROWS:
            begin
                if (out_free && row_reg == 3'(NUM_BINS - 1))
                begin
                    state_next = lhm_pkg::ST_SUMMARY;
                end
            end
            lhm_pkg::ST_SUMMARY:
            begin
                if (out_free)
                begin
                    state_next = lhm_pkg::ST_IDLE;
                end
            end
            default: state_next = lhm_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lhm_pkg::ST_IDLE;
            period_count_reg <= '0;
            period_real_sum_reg <= '0;
            period_process_sum_reg <= '0;
            finished_reg <= '0;
            over_real_reg <= '0;
            over_process_reg <= '0;
            min_rate_reg <= '0;
            max_rate_reg <= '0;
            div_second_reg <= 1'b0;
            row_reg <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_BINS; i++)
            begin
                real_hist_reg[i] <= '0;
                process_hist_reg[i] <= '0;
                wait_hist_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_load || (out_valid_reg && !res.ready);
            case (state_reg)
                lhm_pkg::ST_IDLE:
                begin
                    div_second_reg <= 1'b0;
                    row_reg <= '0;
                end
                lhm_pkg::ST_EVENT:
                begin
                    period_count_reg <= period_count_reg + 32'd1;
                    period_real_sum_reg <= period_real_sum_reg + cur_reg.real_time;
                    period_process_sum_reg <= period_process_sum_reg + cur_reg.process_time;
                    finished_reg <= finished_reg + 32'd1;
                    over_real_reg <= over_real_reg + 32'(cur_reg.over_real);
                    over_process_reg <= over_process_reg + 32'(cur_reg.over_process);
                    for (int i = 0; i < NUM_BINS; i++)
                    begin
                        if (cur_reg.real_bin == 3'(i))
                        begin
                            real_hist_reg[i] <= real_hist_reg[i] + 32'd1;
                        end
                        if (cur_reg.process_bin == 3'(i))
                        begin
                            process_hist_reg[i] <= process_hist_reg[i] + 32'd1;
                        end
                        if (cur_reg.wait_bin == 3'(i))
                        begin
                            wait_hist_reg[i] <= wait_hist_reg[i] + 32'd1;
                        end
                    end
                end
                lhm_pkg::ST_DIV:
                begin
                    if (!div_busy && !div_second_reg)
                    begin
                        div_second_reg <= 1'b1;
                    end
                end
                lhm_pkg::ST_RATE:
                begin
                    if (out_free)
                    begin
                        if (period_real_sum_reg != '0)
                        begin
                            if (min_rate_reg == '0 || min_rate_reg > real_rate_reg)
                            begin
                                min_rate_reg <= real_rate_reg;
                            end
                            if (real_rate_reg > max_rate_reg)
                            begin
                                max_rate_reg <= real_rate_reg;
                            end
                        end
                        else
                        begin
                            min_rate_reg <= '0;
                            max_rate_reg <= '0;
                        end
                        period_count_reg <= '0;
                        period_real_sum_reg <= '0;
                        period_process_sum_reg <= '0;
                    end
                end
                lhm_pkg::ST_ROWS:
                begin
                    if (out_free)
                    begin
                        row_reg <= row_reg + 3'd1;
                        real_hist_reg[row_sel] <= '0;
                        process_hist_reg[row_sel] <= '0;
                        wait_hist_reg[row_sel] <= '0;
                    end
                end
                lhm_pkg::ST_SUMMARY:
                begin
                    if (out_free)
                    begin
                        finished_reg <= '0;
                        over_real_reg <= '0;
                        over_process_reg <= '0;
                    end
                end
                default:
                begin
                    row_reg <= '0;
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (work_pop)
        begin
            cur_reg <= work;
        end
        if (state_reg == lhm_pkg::ST_DIV && !div_busy && !div_second_reg)
        begin
            real_rate_reg <= (period_real_sum_reg == '0) ? '0 : div_q;
        end
        case (state_reg)
            lhm_pkg::ST_RATE:
            begin
                if (out_free)
                begin
                    out_kind_reg <= lhm_pkg::KIND_RATE;
                    bin_index_reg <= '0;
                    va_reg <= real_rate_reg;
                    vb_reg <= (period_process_sum_reg == '0) ? '0 : div_q;
                    vc_reg <= '0;
                    rp_reg <= '0;
                    pp_reg <= '0;
                    last_reg <= 1'b1;
                end
            end
            lhm_pkg::ST_ROWS:
            begin
                if (out_free)
                begin
                    out_kind_reg <= lhm_pkg::KIND_BIN;
                    bin_index_reg <= row_reg;
                    va_reg <= real_hist_reg[row_sel];
                    vb_reg <= process_hist_reg[row_sel];
                    vc_reg <= wait_hist_reg[row_sel];
                    rp_reg <= '0;
                    pp_reg <= '0;
                    last_reg <= 1'b0;
                end
            end
            lhm_pkg::ST_SUMMARY:
            begin
                if (out_free)
                begin
                    out_kind_reg <= lhm_pkg::KIND_SUMMARY;
                    bin_index_reg <= '0;
                    va_reg <= finished_reg;
                    vb_reg <= over_real_reg;
                    vc_reg <= over_process_reg;
                    rp_reg <= pct_of(over_real_reg, finished_reg);
                    pp_reg <= pct_of(over_process_reg, finished_reg);
                    last_reg <= 1'b1;
                end
            end
            default:
            begin
                last_reg <= last_reg;
            end
        endcase
    end

    assign res.valid = out_valid_reg;
    assign res.out_kind = out_kind_reg;
    assign res.bin_index = bin_index_reg;
    assign res.value_a = va_reg;
    assign res.value_b = vb_reg;
    assign res.value_c = vc_reg;
    assign res.real_percent = rp_reg;
    assign res.process_percent = pp_reg;
    assign res.rate_min = min_rate_reg;
    assign res.rate_max = max_rate_reg;
    assign res.last = last_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !res.ready |=> out_valid_reg)
        else $error("result dropped while stalled");
    assert property (@(posedge clk) disable iff (!rst_n)
        work_pop |-> state_reg == lhm_pkg::ST_IDLE)
        else $error("request taken while busy");
    assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("divider restarted while busy");
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == lhm_pkg::ST_ROWS |-> row_reg < 3'(NUM_BINS))
        else $error("bin row out of range");
endmodule
`default_nettype wire

/* src/latency_histogram_monitor.sv */
// Latency histogram monitor: an event request updates counters and three histograms
// by way of the queue, then the back end update. A collect request runs two 64-step
// divisions on the shared bit-serial divider and gives one rate result. A report
// request gives NUM_BOUNDS+1 bin rows and a summary, one result a cycle while the
// output is taken. Requests queue two deep ahead of the back end.
`default_nettype none
module latency_histogram_monitor #(
    parameter int NUM_BOUNDS = lhm_pkg::NUM_BOUNDS_DEF
) (
    input wire logic  clk,
    input wire logic  rst_n,
    lhm_req_if.sink   req,
    lhm_cfg_if.sink   cfg,
    lhm_out_if.source res
);
    lhm_pkg::work_t front_work, queue_work;
    logic q_full, q_not_empty, q_pop;

    assign req.ready = !q_full;

    lhm_front #(.NUM_BOUNDS(NUM_BOUNDS)) u_front (
        .clk(clk), .rst_n(rst_n), .cfg(cfg),
        .in_req_type(req.req_type), .in_real_time(req.real_time),
        .in_process_time(req.process_time), .work(front_work)
    );

    lhm_queue u_queue (
        .clk(clk), .rst_n(rst_n), .push(req.valid && !q_full), .push_data(front_work),
        .full(q_full), .not_empty(q_not_empty), .pop(q_pop), .pop_data(queue_work)
    );

    lhm_back #(.NUM_BOUNDS(NUM_BOUNDS)) u_back (
        .clk(clk), .rst_n(rst_n), .work_valid(q_not_empty), .work(queue_work),
        .work_pop(q_pop), .res(res)
    );
endmodule
`default_nettype wire
